// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("console check failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("console check failed");

`endif

// ===== rtl/core/tccw_pkg.sv =====
// types, constants and microprogram of the text console cell writer
`default_nettype none

package tccw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;
    localparam int CURSOR_W    = 11;

    localparam logic [7:0] RESET_ATTR   = 8'h0B;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NULL      = 8'd0;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [10:0] cursor_index;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
    } t_out_item;

    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] ch;
    } t_cell;

    // microprogram step addresses
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_NL,
        ST_CHECK,
        ST_SC_SETUP,
        ST_SC_READ,
        ST_SC_WRITE,
        ST_SC_BLANK,
        ST_BS_STEP,
        ST_BS_READ,
        ST_BS_WRITE,
        ST_CLR,
        ST_RD_READ,
        ST_DONE,
        ST_DONE_RD
    } t_step;

    // write data select
    typedef enum logic [2:0] {
        WS_CHAR,
        WS_BLANK,
        WS_BLANK_RST,
        WS_BS,
        WS_MOVE
    } t_wsel;

    // write address select
    typedef enum logic {
        AS_CURSOR,
        AS_PTR
    } t_asel;

    // read address select
    typedef enum logic [1:0] {
        RS_CURSOR,
        RS_PTR_UP,
        RS_INDEX
    } t_rsel;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_INC,
        CO_DEC_SAT,
        CO_ZERO,
        CO_UP_ROW
    } t_cur;

    typedef enum logic [1:0] {
        PO_HOLD,
        PO_ZERO,
        PO_INC
    } t_ptr;

    // jump conditions
    typedef enum logic [2:0] {
        JC_ALWAYS,
        JC_DISPATCH,
        JC_COL_LAST,
        JC_AT_END,
        JC_PTR_LAST,
        JC_MOVE_LAST,
        JC_OUT_FREE
    } t_jmp;

    typedef struct packed {
        logic  mem_we;
        t_wsel wsel;
        t_asel wadr;
        t_rsel radr;
        t_cur  cur_op;
        t_ptr  ptr_op;
        logic  out_ld;
        logic  out_rd;
        t_jmp  jmp;
        t_step jmp_hit;
        t_step jmp_miss;
    } t_ctrl;

    // control store
    function automatic t_ctrl f_ucode(input t_step step);
        t_ctrl cw;
        cw = '{mem_we: 1'b0, wsel: WS_BLANK, wadr: AS_CURSOR, radr: RS_CURSOR,
               cur_op: CO_HOLD, ptr_op: PO_HOLD, out_ld: 1'b0, out_rd: 1'b0,
               jmp: JC_ALWAYS, jmp_hit: ST_IDLE, jmp_miss: ST_IDLE};
        unique case (step)
            ST_INIT: begin
                cw.mem_we = 1'b1; cw.wsel = WS_BLANK_RST; cw.wadr = AS_PTR;
                cw.ptr_op = PO_INC;
                cw.jmp = JC_PTR_LAST; cw.jmp_hit = ST_IDLE; cw.jmp_miss = ST_INIT;
            end
            ST_IDLE: begin
                cw.ptr_op = PO_ZERO;
                cw.jmp = JC_DISPATCH; cw.jmp_miss = ST_IDLE;
            end
            ST_PUT: begin
                cw.mem_we = 1'b1; cw.wsel = WS_CHAR; cw.wadr = AS_CURSOR;
                cw.cur_op = CO_INC;
                cw.jmp = JC_ALWAYS; cw.jmp_hit = ST_CHECK;
            end
            ST_NL: begin
                cw.mem_we = 1'b1; cw.wsel = WS_BLANK; cw.wadr = AS_CURSOR;
                cw.cur_op = CO_INC;
                cw.jmp = JC_COL_LAST; cw.jmp_hit = ST_CHECK; cw.jmp_miss = ST_NL;
            end
            ST_CHECK: begin
                cw.jmp = JC_AT_END; cw.jmp_hit = ST_SC_SETUP; cw.jmp_miss = ST_DONE;
            end
            ST_SC_SETUP: begin
                cw.cur_op = CO_UP_ROW;
                cw.jmp = JC_ALWAYS; cw.jmp_hit = ST_SC_READ;
            end
            ST_SC_READ: begin
                cw.radr = RS_PTR_UP;
                cw.jmp = JC_ALWAYS; cw.jmp_hit = ST_SC_WRITE;
            end
            ST_SC_WRITE: begin
                cw.mem_we = 1'b1; cw.wsel = WS_MOVE; cw.wadr = AS_PTR;
                cw.ptr_op = PO_INC;
                cw.jmp = JC_MOVE_LAST; cw.jmp_hit = ST_SC_BLANK; cw.jmp_miss = ST_SC_READ;
            end
            ST_SC_BLANK: begin
                cw.mem_we = 1'b1; cw.wsel = WS_BLANK; cw.wadr = AS_PTR;
                cw.ptr_op = PO_INC;
                cw.jmp = JC_PTR_LAST; cw.jmp_hit = ST_DONE; cw.jmp_miss = ST_SC_BLANK;
            end
            ST_BS_STEP: begin
                cw.cur_op = CO_DEC_SAT;
                cw.jmp = JC_ALWAYS; cw.jmp_hit = ST_BS_READ;
            end
            ST_BS_READ: begin
                cw.radr = RS_CURSOR;
                cw.jmp = JC_ALWAYS; cw.jmp_hit = ST_BS_WRITE;
            end
            ST_BS_WRITE: begin
                cw.mem_we = 1'b1; cw.wsel = WS_BS; cw.wadr = AS_CURSOR;
                cw.jmp = JC_ALWAYS; cw.jmp_hit = ST_DONE;
            end
            ST_CLR: begin
                cw.mem_we = 1'b1; cw.wsel = WS_BLANK; cw.wadr = AS_PTR;
                cw.ptr_op = PO_INC; cw.cur_op = CO_ZERO;
                cw.jmp = JC_PTR_LAST; cw.jmp_hit = ST_DONE; cw.jmp_miss = ST_CLR;
            end
            ST_RD_READ: begin
                cw.radr = RS_INDEX;
                cw.jmp = JC_ALWAYS; cw.jmp_hit = ST_DONE_RD;
            end
            ST_DONE: begin
                cw.out_ld = 1'b1;
                cw.jmp = JC_OUT_FREE; cw.jmp_hit = ST_IDLE; cw.jmp_miss = ST_DONE;
            end
            ST_DONE_RD: begin
                cw.radr = RS_INDEX; cw.out_ld = 1'b1; cw.out_rd = 1'b1;
                cw.jmp = JC_OUT_FREE; cw.jmp_hit = ST_IDLE; cw.jmp_miss = ST_DONE_RD;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/text_console_cell_writer_top.sv =====
// text console cell writer: microcoded sequencer over a cell memory with one write and one read port
// one item at a time; the next transfer is taken once the sequencer is back in its idle step
// a cleared or blanked cell takes one memory write; a scrolled cell a read step then a write step
// reset is synchronous, active low; it starts a clearing pass over all CELLS cells that fills the
//   memory with space and attribute 0x0B while input stalls (config writes still taken)
`default_nettype none

module text_console_cell_writer_top #(
    parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output      logic                o_stall,
    input  wire tccw_pkg::t_in_item  i_in,
    output      logic                o_valid,
    input  wire logic                i_stall,
    output      tccw_pkg::t_out_item o_out,
    input  wire logic                i_cfg_we,
    input  wire logic [7:0]          i_cfg_data
);
    import tccw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int COLW  = $clog2(COLUMNS);

    localparam logic [AW-1:0]   PTR_LAST  = AW'(CELLS - 1);
    localparam logic [AW-1:0]   MOVE_LAST = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0]   ROW_PTR   = AW'(COLUMNS);
    localparam logic [CW-1:0]   CUR_END   = CW'(CELLS);
    localparam logic [CW-1:0]   ROW_CUR   = CW'(COLUMNS);
    localparam logic [COLW-1:0] COL_LAST  = COLW'(COLUMNS - 1);

    // sequencer
    t_step           r_step, n_step;
    t_ctrl           ctrl;
    logic            taken;
    t_step           dispatch_step;

    // datapath registers
    logic [CW-1:0]   r_cursor, n_cursor;
    logic [COLW-1:0] r_col, n_col;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [7:0]      r_ch;
    logic [10:0]     r_idx;
    logic [7:0]      r_attr;

    // cell memory, registered read
    t_cell           r_mem [CELLS];
    t_cell           r_rdata;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    t_cell           wr_data;

    // result register
    t_out_item       r_out;
    logic            r_out_valid;
    logic            out_free;
    logic            in_accept;

    assign in_accept = i_valid && (r_step == ST_IDLE);
    assign out_free  = !(r_out_valid && i_stall);
    assign o_stall   = (r_step != ST_IDLE);
    assign o_valid   = r_out_valid;
    assign o_out     = r_out;

    // control word of the current step
    always_comb begin
        ctrl = f_ucode(r_step);
    end

    // opcode decode of an incoming item into its first step
    always_comb begin
        dispatch_step = ST_DONE;
        unique case (i_in.mode)
            MODE_PUT: begin
                priority if (i_in.char_code == CH_NEWLINE)   dispatch_step = ST_NL;
                else if     (i_in.char_code == CH_BACKSPACE) dispatch_step = ST_BS_STEP;
                else if     (i_in.char_code == CH_NULL)      dispatch_step = ST_DONE;
                else                                         dispatch_step = ST_PUT;
            end
            MODE_CLEAR: dispatch_step = ST_CLR;
            // out-of-range read skips the memory and returns zeros
            MODE_READ:  dispatch_step = (int'(i_in.cell_index) < CELLS) ? ST_RD_READ : ST_DONE;
            default:    dispatch_step = ST_DONE;
        endcase
    end

    // jump condition
    always_comb begin
        unique case (ctrl.jmp)
            JC_ALWAYS:    taken = 1'b1;
            JC_DISPATCH:  taken = in_accept;
            JC_COL_LAST:  taken = (r_col == COL_LAST);
            JC_AT_END:    taken = (r_cursor == CUR_END);
            JC_PTR_LAST:  taken = (r_ptr == PTR_LAST);
            JC_MOVE_LAST: taken = (r_ptr == MOVE_LAST);
            JC_OUT_FREE:  taken = out_free;
            default:      taken = 1'b0;
        endcase
    end

    // step counter next value
    always_comb begin
        if (ctrl.jmp == JC_DISPATCH) begin
            n_step = taken ? dispatch_step : ctrl.jmp_miss;
        end else begin
            n_step = taken ? ctrl.jmp_hit : ctrl.jmp_miss;
        end
    end

    // cursor and column; column tracks cursor so no modulo is needed
    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        unique case (ctrl.cur_op)
            CO_HOLD: ;
            CO_INC: begin
                n_cursor = r_cursor + 1'b1;
                n_col    = (r_col == COL_LAST) ? '0 : r_col + 1'b1;
            end
            CO_DEC_SAT: begin
                // backspace at cell 0 stays put
                if (r_cursor != '0) begin
                    n_cursor = r_cursor - 1'b1;
                    n_col    = (r_col == '0) ? COL_LAST : r_col - 1'b1;
                end
            end
            CO_ZERO: begin
                n_cursor = '0;
                n_col    = '0;
            end
            CO_UP_ROW: n_cursor = r_cursor - ROW_CUR;
            default: ;
        endcase
    end

    // walk pointer for clear, scroll and the reset pass
    always_comb begin
        unique case (ctrl.ptr_op)
            PO_ZERO: n_ptr = '0;
            PO_INC:  n_ptr = r_ptr + 1'b1;
            default: n_ptr = r_ptr;
        endcase
    end

    // memory address and data selection
    always_comb begin
        wr_addr = (ctrl.wadr == AS_PTR) ? r_ptr : r_cursor[AW-1:0];
        unique case (ctrl.radr)
            RS_PTR_UP: rd_addr = r_ptr + ROW_PTR;
            RS_INDEX:  rd_addr = AW'(r_idx);
            default:   rd_addr = r_cursor[AW-1:0];
        endcase
        unique case (ctrl.wsel)
            WS_CHAR:      wr_data = '{attr: r_attr, ch: r_ch};
            WS_BLANK:     wr_data = '{attr: r_attr, ch: CH_SPACE};
            WS_BLANK_RST: wr_data = '{attr: RESET_ATTR, ch: CH_SPACE};
            WS_BS:        wr_data = '{attr: r_rdata.attr, ch: CH_SPACE};
            WS_MOVE:      wr_data = r_rdata;
            default:      wr_data = r_rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n && ctrl.mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= ST_INIT;
            r_cursor <= '0;
            r_col    <= '0;
            r_ptr    <= '0;
            r_attr   <= RESET_ATTR;
        end else begin
            r_step   <= n_step;
            r_cursor <= n_cursor;
            r_col    <= n_col;
            r_ptr    <= n_ptr;
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
        end
    end

    // item capture on input transfer
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch  <= i_in.char_code;
            r_idx <= i_in.cell_index;
        end
    end

    // result register: loads only when empty or draining this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_ld && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_ld && out_free) begin
            r_out.cursor_index <= CURSOR_W'(r_cursor);
            r_out.read_char    <= ctrl.out_rd ? r_rdata.ch : 8'd0;
            r_out.read_attr    <= ctrl.out_rd ? r_rdata.attr : 8'd0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tccw_checker.sv =====
// port-level checker for the text console cell writer and its bind
`default_nettype none
`include "assert_macros.svh"

module tccw_checker #(
    parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire tccw_pkg::t_out_item o_out
);
    import tccw_pkg::*;

    localparam int  CELLS    = COLUMNS * ROWS;
    localparam bit  WIDE_SCR = (CELLS > 2047);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out))

    // an accepted item keeps the block busy in the next cycle
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // a new result only shows once the sequencer is back at rest
    `ASSERT_NOW(a_result_at_rest, i_clk, i_rst_n, $rose(o_valid), !o_stall)

    // cursor always lands on the screen; checked only for screens of at most 2047 cells
    `ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, o_valid,
                WIDE_SCR || (int'(o_out.cursor_index) < CELLS))

endmodule

bind text_console_cell_writer_top tccw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tccw_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_out  (o_out)
);

`default_nettype wire
